[rtl/core/linear_probe_hash_table_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the linear probing hash table
// Clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_TABLE_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_ASSERT_SVH

// Same-cycle implication.
`define LPHT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LPHT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/lpht_pkg.sv]
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared widths, operation and status codes, and the slot entry type.
// ----------------------------------------------------------------------------
package lpht_pkg;

    localparam int KEY_W    = 17;
    localparam int POP_W    = 24;
    localparam int CFG_W    = 15;
    localparam int STATUS_W = 2;
    localparam int PROBE_W  = 15;
    localparam int SLOT_W   = 14;

    localparam logic [CFG_W-1:0] CFG_RESET = 15'd16384;

    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_INSERT = 1'b1;

    localparam logic [STATUS_W-1:0] ST_HIT  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
    } slot_entry_t;

endpackage

[rtl/core/lpht_mod_unit.sv]
// ----------------------------------------------------------------------------
// lpht_mod_unit
// Restoring remainder unit: one key bit per cycle, one subtract and compare.
// ----------------------------------------------------------------------------
module lpht_mod_unit import lpht_pkg::*; #(
    parameter int DIV_W = 15
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [KEY_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] remainder
);

    localparam int CNT_W = $clog2(KEY_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(KEY_W - 1);

    typedef enum logic {M_IDLE, M_RUN} mstate_t;

    mstate_t          state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [KEY_W-1:0] dvd_reg, dvd_next;
    logic [DIV_W-1:0] div_reg, div_next;
    logic [DIV_W-1:0] rem_reg, rem_next;

    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;
    logic [DIV_W-1:0] step;

    // The partial remainder stays below the divisor, so the trial value
    // fits one extra bit and one subtraction restores it.
    always_comb
    begin
        trial = {rem_reg, dvd_reg[KEY_W-1]};
        diff  = trial - {1'b0, div_reg};
        if (trial >= {1'b0, div_reg})
        begin
            step = diff[DIV_W-1:0];
        end
        else
        begin
            step = trial[DIV_W-1:0];
        end
    end

    assign done      = (state_reg == M_RUN) && (cnt_reg == CNT_LAST);
    assign remainder = step;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        dvd_next   = dvd_reg;
        div_next   = div_reg;
        rem_next   = rem_reg;
        case (state_reg)
            M_IDLE:
            begin
                if (start)
                begin
                    dvd_next   = dividend;
                    div_next   = divisor;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = M_RUN;
                end
            end
            M_RUN:
            begin
                rem_next = step;
                dvd_next = {dvd_reg[KEY_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = M_IDLE;
                end
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

endmodule

[rtl/core/lpht_slot_mem.sv]
// ----------------------------------------------------------------------------
// lpht_slot_mem
// Slot storage: valid and key with a registered read port, payload alongside.
// ----------------------------------------------------------------------------
module lpht_slot_mem import lpht_pkg::*; #(
    parameter int DEPTH = 16384,
    parameter int AW    = 14
) (
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  slot_entry_t       wdata,
    input  logic [POP_W-1:0]  wpop,
    input  logic [AW-1:0]     raddr,
    output slot_entry_t       rdata
);

    slot_entry_t      entry_mem [DEPTH];
    logic [POP_W-1:0] pop_mem   [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            entry_mem[waddr] <= wdata;
            pop_mem[waddr]   <= wpop;
        end
        rdata <= entry_mem[raddr];
    end

endmodule

[rtl/core/linear_probe_hash_table.sv]
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// The bit-serial remainder unit reduces the KEY_W (17) bit key to the home slot,
// then the walk examines one slot per cycle, at least one slot in all.
// A new command is taken only once the last result is out, and it can transfer in
// the cycle that done is high. Results cannot be stalled.
// Reset: asynchronous, active low. After reset a clearing pass over all CAPACITY
// slots empties every slot while busy is high; config writes still transfer.
// ----------------------------------------------------------------------------
`include "linear_probe_hash_table_assert.svh"

module linear_probe_hash_table import lpht_pkg::*; #(
    parameter int CAPACITY = 16384
) (
    input  logic                clk,
    input  logic                rst_n,

    // Command side: an item transfers when start is high and busy is low.
    input  logic                start,
    output logic                busy,
    input  logic                func,
    input  logic [KEY_W-1:0]    key,
    input  logic [POP_W-1:0]    population,

    // Result side: done marks a single-cycle result.
    output logic                done,
    output logic [STATUS_W-1:0] status,
    output logic [PROBE_W-1:0]  probes,
    output logic [SLOT_W-1:0]   slot,

    // Configuration: table_size write channel.
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CFG_W-1:0]    cfg_data
);

    // Slot index width, and a width that can hold the size itself.
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int SZ_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CFG_W > SZ_W) ? CFG_W : SZ_W;
    localparam logic [IDX_W-1:0] CLR_LAST = IDX_W'(CAPACITY - 1);

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_MOD, S_PROBE} state_t;

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    clr_reg, clr_next;
    logic [CFG_W-1:0]    size_cfg_reg;

    // Item context held for the whole probe walk.
    logic                func_reg, func_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [POP_W-1:0]    pop_reg, pop_next;
    logic [SZ_W-1:0]     size_reg, size_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [SZ_W-1:0]     cnt_reg, cnt_next;

    // Registered result.
    logic                done_reg, done_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [PROBE_W-1:0]  probes_reg, probes_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;

    logic [SZ_W-1:0]     eff_size;
    logic [CMP_W-1:0]    cfg_ext;
    logic                mod_start;
    logic                mod_done;
    logic [SZ_W-1:0]     mod_rem;

    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    slot_entry_t         mem_wdata;
    logic [POP_W-1:0]    mem_wpop;
    logic [IDX_W-1:0]    mem_raddr;
    slot_entry_t         mem_rdata;

    logic [IDX_W:0]      idx_inc;
    logic [IDX_W-1:0]    idx_wrap;
    logic [SZ_W-1:0]     cnt_inc;

    // The effective size is copied into the item context when a command
    // transfers, so a write can always be taken and never disturbs an item
    // that is already being walked.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_cfg_reg <= CFG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            size_cfg_reg <= cfg_data;
        end
    end

    // A size of zero behaves as one, and a size beyond the storage behaves
    // as the full storage.
    always_comb
    begin
        cfg_ext = CMP_W'(size_cfg_reg);
        if (size_cfg_reg == '0)
        begin
            eff_size = SZ_W'(1);
        end
        else if (cfg_ext > CMP_W'(CAPACITY))
        begin
            eff_size = SZ_W'(CAPACITY);
        end
        else
        begin
            eff_size = SZ_W'(cfg_ext);
        end
    end

    // The home slot comes from the remainder unit, which starts on the
    // same edge that the command transfers.
    lpht_mod_unit #(
        .DIV_W (SZ_W)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (key),
        .divisor   (eff_size),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    lpht_slot_mem #(
        .DEPTH (CAPACITY),
        .AW    (IDX_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .wpop  (mem_wpop),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Next slot on the probe path wraps at the effective size, not at the
    // storage depth.
    assign idx_inc  = {1'b0, idx_reg} + 1'b1;
    assign idx_wrap = (idx_inc == (IDX_W + 1)'(size_reg)) ? '0 : idx_inc[IDX_W-1:0];
    assign cnt_inc  = cnt_reg + 1'b1;

    // Sequencer. In the probe state the read data belongs to idx_reg, and the
    // read for the following slot is issued in the same cycle so the walk
    // examines one slot per cycle. A read issued on the final probe is simply
    // dropped.
    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        func_next   = func_reg;
        key_next    = key_reg;
        pop_next    = pop_reg;
        size_next   = size_reg;
        idx_next    = idx_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        probes_next = probes_reg;
        slot_next   = slot_reg;
        mod_start   = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = idx_reg;
        mem_wdata   = '{valid: 1'b1, key: key_reg};
        mem_wpop    = pop_reg;
        mem_raddr   = idx_reg;

        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '{valid: 1'b0, key: '0};
                mem_wpop  = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == CLR_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    func_next  = func;
                    key_next   = key;
                    pop_next   = population;
                    size_next  = eff_size;
                    mod_start  = 1'b1;
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                mem_raddr = IDX_W'(mod_rem);
                if (mod_done)
                begin
                    idx_next   = IDX_W'(mod_rem);
                    cnt_next   = '0;
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                mem_raddr = idx_wrap;
                if (!mem_rdata.valid)
                begin
                    // Empty slot: a lookup misses here, an insert stores here.
                    done_next   = 1'b1;
                    probes_next = PROBE_W'(cnt_reg);
                    state_next  = S_IDLE;
                    if (func_reg == FUNC_INSERT)
                    begin
                        mem_we      = 1'b1;
                        status_next = ST_HIT;
                        slot_next   = SLOT_W'(idx_reg);
                    end
                    else
                    begin
                        status_next = ST_MISS;
                        slot_next   = '0;
                    end
                end
                else if ((func_reg == FUNC_LOOKUP) && (mem_rdata.key == key_reg))
                begin
                    done_next   = 1'b1;
                    status_next = ST_HIT;
                    probes_next = PROBE_W'(cnt_inc);
                    slot_next   = SLOT_W'(idx_reg);
                    state_next  = S_IDLE;
                end
                else if (cnt_inc == size_reg)
                begin
                    // Every slot in use has been examined.
                    done_next   = 1'b1;
                    status_next = (func_reg == FUNC_INSERT) ? ST_FULL : ST_MISS;
                    probes_next = PROBE_W'(cnt_inc);
                    slot_next   = '0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    idx_next = idx_wrap;
                    cnt_next = cnt_inc;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        key_reg    <= key_next;
        pop_reg    <= pop_next;
        size_reg   <= size_next;
        idx_reg    <= idx_next;
        cnt_reg    <= cnt_next;
        status_reg <= status_next;
        probes_reg <= probes_next;
        slot_reg   <= slot_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign status = status_reg;
    assign probes = probes_reg;
    assign slot   = slot_reg;

    // A transferred command always occupies the block on the next cycle.
    `LPHT_ASSERT_NEXT(a_start_busy, start && !busy, busy, "command transfer did not set busy")

    // The remainder unit never delivers a home slot outside the table.
    `LPHT_ASSERT_IMPL(a_home_range, (state_reg == S_MOD) && mod_done, mod_rem < size_reg,
        "home slot beyond the effective size")

    // The walk never examines more slots than the table holds.
    `LPHT_ASSERT_IMPL(a_probe_bound, state_reg == S_PROBE,
        (cnt_reg < size_reg) && (SZ_W'(idx_reg) < size_reg), "probe walk out of bounds")

    // Only a found or stored result names a slot, and full only follows an insert.
    `LPHT_ASSERT_NEXT(a_result_shape, done_next,
        ((status == ST_HIT) || (slot == '0)) && ((status != ST_FULL) || (func_reg == FUNC_INSERT)),
        "result fields inconsistent with status")

endmodule

[bench/tb_linear_probe_hash_table.sv]
`timescale 1ns / 100ps
// ============================================================================
// tb_linear_probe_hash_table
// Self-checking bench for the linear probing hash table. A shadow copy of the
// slot store predicts status, probe count and slot for every command, and the
// monitor checks each result against the oldest prediction.
// ============================================================================
module tb_linear_probe_hash_table;

    import lpht_pkg::*;

    localparam int TABLE_DEPTH = 16384;
    // A run without any transfer that reaches STALL_LIMIT means the block is stuck.
    // The longest legal gaps are the clearing pass and a full walk of the table.
    localparam int STALL_LIMIT = 100000;
    localparam int KEY_MAX     = 99999;
    localparam int PHASES      = 16;

    typedef struct packed {
        logic             fn;
        logic [KEY_W-1:0] k;
        logic [POP_W-1:0] pop;
    } hash_cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PROBE_W-1:0]  probes;
        logic [SLOT_W-1:0]   slot;
    } probe_result_t;

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                start      = 1'b0;
    logic                func       = FUNC_LOOKUP;
    logic [KEY_W-1:0]    key        = '0;
    logic [POP_W-1:0]    population = '0;
    logic                cfg_valid  = 1'b0;
    logic [CFG_W-1:0]    cfg_data   = '0;
    logic                busy;
    logic                done;
    logic                cfg_ready;
    logic [STATUS_W-1:0] status;
    logic [PROBE_W-1:0]  probes;
    logic [SLOT_W-1:0]   slot;

    linear_probe_hash_table #(
        .CAPACITY (TABLE_DEPTH)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .func       (func),
        .key        (key),
        .population (population),
        .done       (done),
        .status     (status),
        .probes     (probes),
        .slot       (slot),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Shadow state of the block: the slot store and the size register.
    // Keys are only read where the valid bit is set, so unwritten entries
    // never influence a prediction.
    // ------------------------------------------------------------------------
    bit               shadow_valid [TABLE_DEPTH];
    logic [KEY_W-1:0] shadow_key   [TABLE_DEPTH];
    logic [POP_W-1:0] shadow_pop   [TABLE_DEPTH];
    logic [CFG_W-1:0] size_shadow  = CFG_RESET;

    hash_cmd_t        cmd_q[$];          // commands waiting for the driver
    probe_result_t    outcome_q[$];      // predicted results, oldest first
    logic [KEY_W-1:0] stored_keys[$];    // keys inserted so far, for lookups

    int  items_queued   = 0;
    int  results_seen   = 0;
    int  mismatch_count = 0;
    int  quiet_cycles   = 0;
    bit  sender_idles   = 1'b1;

    logic [CFG_W-1:0] phase_sizes [0:PHASES-1] = '{
        15'd3, 15'd7, 15'd0, 15'd64, 15'd16384, 15'd1, 15'd100, 15'd32767,
        15'd13, 15'd257, 15'd2, 15'd1000, 15'd31, 15'd5000, 15'd16385, 15'd16
    };

    // A size of zero behaves as one slot; anything above the capacity is
    // clamped to the capacity.
    function automatic int active_span();
        if (size_shadow == '0)
        begin
            return 1;
        end
        if (int'(size_shadow) > TABLE_DEPTH)
        begin
            return TABLE_DEPTH;
        end
        return int'(size_shadow);
    endfunction

    // Walks the shadow store exactly as the block should and updates it on a
    // successful insert. Occupied slots passed over count as probes.
    function automatic probe_result_t walk_table(input hash_cmd_t c);
        probe_result_t r;
        int            span;
        int            pos;
        int            n;
        span     = active_span();
        pos      = int'(c.k) % span;
        r.status = (c.fn == FUNC_INSERT) ? ST_FULL : ST_MISS;
        r.probes = '0;
        r.slot   = '0;
        for (n = 0; n < span; n++)
        begin
            if (!shadow_valid[pos])
            begin
                if (c.fn == FUNC_INSERT)
                begin
                    shadow_valid[pos] = 1'b1;
                    shadow_key[pos]   = c.k;
                    shadow_pop[pos]   = c.pop;
                    r.status          = ST_HIT;
                    r.slot            = SLOT_W'(pos);
                end
                break;
            end
            r.probes = r.probes + 1'b1;
            if (c.fn == FUNC_LOOKUP && shadow_key[pos] == c.k)
            begin
                r.status = ST_HIT;
                r.slot   = SLOT_W'(pos);
                break;
            end
            pos = (pos + 1 == span) ? 0 : pos + 1;
        end
        return r;
    endfunction

    task automatic note_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic push_cmd(input logic fn, input int k, input logic [POP_W-1:0] pop);
        hash_cmd_t c;
        c.fn  = fn;
        c.k   = KEY_W'(k);
        c.pop = pop;
        cmd_q.push_back(c);
        items_queued++;
    endtask

    // Mostly inserts and lookups of keys that were stored before, so that
    // hits, clusters and full tables are reached; the rest are lookups of
    // arbitrary keys. Some inserts reuse the home slot of an older key.
    task automatic push_random_phase(input int n_items);
        int unsigned roll;
        int          k;
        int          span;
        repeat (n_items)
        begin
            span = active_span();
            roll = $urandom_range(99);
            k    = $urandom_range(KEY_MAX);
            if (roll < 45)
            begin
                if (roll < 12 && stored_keys.size() != 0)
                begin
                    k = int'(stored_keys[$urandom_range(stored_keys.size() - 1)])
                        + span * $urandom_range(3);
                    if (k > KEY_MAX)
                    begin
                        k = k % span;
                    end
                end
                stored_keys.push_back(KEY_W'(k));
                push_cmd(FUNC_INSERT, k, POP_W'($urandom));
            end
            else if (roll < 82 && stored_keys.size() != 0)
            begin
                k = int'(stored_keys[$urandom_range(stored_keys.size() - 1)]);
                push_cmd(FUNC_LOOKUP, k, POP_W'($urandom));
            end
            else
            begin
                push_cmd(FUNC_LOOKUP, k, POP_W'($urandom));
            end
        end
    endtask

    // Holds until every queued command has produced its result and the block
    // reports idle. The sender has nothing left to send meanwhile.
    task automatic wait_for_drain;
        do
        begin
            @(posedge clk);
        end
        while (results_seen != items_queued || busy);
    endtask

    task automatic write_table_size(input logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid   <= 1'b0;
        size_shadow  = value;
    endtask

    // ------------------------------------------------------------------------
    // Driver: a command transfers at an edge where start is high and busy is
    // low. The prediction is made at that edge, from the values that were on
    // the ports. A command that has not transferred yet stays on the ports.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : driver_p
        hash_cmd_t next_cmd;
        hash_cmd_t sent_cmd;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                sent_cmd.fn  = func;
                sent_cmd.k   = key;
                sent_cmd.pop = population;
                outcome_q.push_back(walk_table(sent_cmd));
            end
            if (start && busy)
            begin
                // Still waiting for the block to take the current command.
            end
            else if (cmd_q.size() != 0 && !(sender_idles && $urandom_range(99) < 14))
            begin
                next_cmd   = cmd_q.pop_front();
                start      <= 1'b1;
                func       <= next_cmd.fn;
                key        <= next_cmd.k;
                population <= next_cmd.pop;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: every done pulse is a result and must match the oldest
    // prediction. The watchdog counts edges without any transfer at all.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor_p
        probe_result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                results_seen++;
                if (outcome_q.size() == 0)
                begin
                    note_mismatch($sformatf("unexpected result status=%0d probes=%0d slot=%0d",
                                            status, probes, slot));
                end
                else
                begin
                    want = outcome_q.pop_front();
                    if (status !== want.status)
                    begin
                        note_mismatch($sformatf("status %0d, predicted %0d",
                                                status, want.status));
                    end
                    if (probes !== want.probes)
                    begin
                        note_mismatch($sformatf("probes %0d, predicted %0d",
                                                probes, want.probes));
                    end
                    if (slot !== want.slot)
                    begin
                        note_mismatch($sformatf("slot %0d, predicted %0d",
                                                slot, want.slot));
                    end
                end
            end
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
                $display("** linear_probe_hash_table: FAILED **");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus. The block is drained before every size change, which also
    // makes the sender pause until all results are in.
    // ------------------------------------------------------------------------
    initial
    begin : stimulus_p
        int p;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset size: empty lookup, a cluster at slot 0 with a duplicate key,
        // a miss at the end of the cluster, and a wrap from the last slot.
        push_cmd(FUNC_LOOKUP, 0, '0);
        push_cmd(FUNC_INSERT, 0, '0);
        push_cmd(FUNC_INSERT, 16384, '1);
        push_cmd(FUNC_INSERT, KEY_MAX, 24'h123456);
        push_cmd(FUNC_LOOKUP, 16384, '1);
        push_cmd(FUNC_INSERT, 0, 24'h00A5A5);
        push_cmd(FUNC_LOOKUP, 0, '0);
        push_cmd(FUNC_LOOKUP, 32768, '0);
        push_cmd(FUNC_LOOKUP, KEY_MAX, '0);
        push_cmd(FUNC_INSERT, 16383, 24'h5A5A5A);
        push_cmd(FUNC_INSERT, 32767, 24'hFFFF00);
        push_cmd(FUNC_LOOKUP, 32767, '0);
        wait_for_drain();

        // Size zero acts as one slot, already taken: full circle and full.
        write_table_size('0);
        push_cmd(FUNC_LOOKUP, 0, '0);
        push_cmd(FUNC_LOOKUP, 5, '0);
        push_cmd(FUNC_INSERT, 7, '1);
        wait_for_drain();

        // Four slots, all occupied from before.
        write_table_size(15'd4);
        push_cmd(FUNC_INSERT, 1, '1);
        push_cmd(FUNC_LOOKUP, 2, '0);
        push_cmd(FUNC_LOOKUP, 32767, '0);
        wait_for_drain();

        // Above capacity: the high entries become visible again.
        write_table_size('1);
        push_cmd(FUNC_LOOKUP, 16383, '0);
        push_cmd(FUNC_LOOKUP, KEY_MAX, '0);
        wait_for_drain();

        for (p = 0; p < PHASES; p++)
        begin
            // Phases 4 and 5 run with the sender never idling.
            sender_idles = !(p == 4 || p == 5);
            write_table_size(phase_sizes[p]);
            push_random_phase($urandom_range(80, 100));
            wait_for_drain();
        end

        repeat (64) @(posedge clk);
        if (outcome_q.size() != 0)
        begin
            note_mismatch($sformatf("%0d predicted results never arrived", outcome_q.size()));
        end
        if (mismatch_count == 0)
        begin
            $display("** linear_probe_hash_table: PASSED **");
        end
        else
        begin
            $display("** linear_probe_hash_table: FAILED **");
        end
        $finish;
    end

endmodule
